### hdl/websocket_frame_deframer_top_defines.svh
// Assertion macros for the WebSocket frame deframer.
// No dependencies; included by the top level.
`ifndef WEBSOCKET_FRAME_DEFRAMER_TOP_DEFINES_SVH
`define WEBSOCKET_FRAME_DEFRAMER_TOP_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define WSFD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("deframer check failed");

// Next-cycle implication, checked out of reset
`define WSFD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("deframer check failed");

`endif

### hdl/wsfd_pkg.sv
// Shared types, constants and helpers for the WebSocket frame deframer.
// No dependencies.
package wsfd_pkg;

    // Header bit masks and markers
    localparam logic [7:0] FIN_MASK    = 8'h80;
    localparam logic [7:0] OPCODE_MASK = 8'h0F;
    localparam logic [7:0] LEN_MASK    = 8'h7F;
    localparam logic [6:0] LEN_EXT16   = 7'd126;

    // Opcodes
    localparam logic [3:0] OP_TEXT   = 4'h1;
    localparam logic [3:0] OP_BINARY = 4'h2;
    localparam logic [3:0] OP_CLOSE  = 4'h8;
    localparam logic [3:0] OP_PING   = 4'h9;
    localparam logic [3:0] OP_PONG   = 4'hA;

    localparam logic [15:0] CAP_RESET = 16'd16384;

    // Parser phase, one-hot
    typedef enum logic [5:0] {
        PH_OPCODE  = 6'b000001,
        PH_LEN     = 6'b000010,
        PH_LEN_HI  = 6'b000100,
        PH_LEN_LO  = 6'b001000,
        PH_PAYLOAD = 6'b010000,
        PH_HALT    = 6'b100000
    } t_phase;

    // Reported frame kind
    typedef enum logic [2:0] {
        KIND_TEXT    = 3'd0,
        KIND_BINARY  = 3'd1,
        KIND_CLOSE   = 3'd2,
        KIND_PING    = 3'd3,
        KIND_PONG    = 3'd4,
        KIND_UNKNOWN = 3'd5,
        KIND_LENERR  = 3'd6
    } t_kind;

    // One result item
    typedef struct packed {
        t_kind       frame_kind;
        logic [3:0]  raw_opcode;
        logic [7:0]  payload_byte;
        logic        has_byte;
        logic        frame_end;
        logic        fin_flag;
        logic        truncated;
        logic        reconnect_request;
        logic        pong_request;
        logic [31:0] audio_byte_total;
    } t_result;

    function automatic t_kind kind_of(input logic [3:0] op);
        t_kind k;
        case (op)
            OP_TEXT:   k = KIND_TEXT;
            OP_BINARY: k = KIND_BINARY;
            OP_CLOSE:  k = KIND_CLOSE;
            OP_PING:   k = KIND_PING;
            OP_PONG:   k = KIND_PONG;
            default:   k = KIND_UNKNOWN;
        endcase
        return k;
    endfunction

endpackage

### hdl/wsfd_parser.sv
// Byte-wise frame header parser and payload forwarding decision.
// Depends on wsfd_pkg.
module wsfd_parser import wsfd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  logic [7:0]  i_byte,
    input  logic [15:0] i_cap,
    output logic        o_res_valid,
    output t_result     o_res
);

    t_phase      r_phase,  n_phase;
    logic [3:0]  r_opcode, n_opcode;
    logic        r_fin,    n_fin;
    logic [15:0] r_len,    n_len;
    logic [15:0] r_seen,   n_seen;
    logic [31:0] r_audio,  n_audio;

    t_kind       cur_kind;
    logic        is_data;
    logic        over;
    logic        fwd;
    logic        last;
    logic [15:0] seen_inc;
    logic [15:0] hdr_len;
    logic [6:0]  len7;
    logic        emit;
    t_result     res;

    assign cur_kind = kind_of(r_opcode);
    assign is_data  = (cur_kind == KIND_TEXT) || (cur_kind == KIND_BINARY);
    assign over     = is_data && (r_len > i_cap);
    assign fwd      = ((cur_kind == KIND_TEXT) && (r_seen < i_cap)) ||
                      ((cur_kind == KIND_BINARY) && !over);
    assign seen_inc = r_seen + 16'd1;
    assign last     = (seen_inc >= r_len);
    assign len7     = 7'(i_byte & LEN_MASK);

    // Next state and result for the byte on the input
    always_comb begin
        n_phase  = r_phase;
        n_opcode = r_opcode;
        n_fin    = r_fin;
        n_len    = r_len;
        n_seen   = r_seen;
        n_audio  = r_audio;
        emit     = 1'b0;
        hdr_len  = 16'd0;
        res      = '0;
        res.frame_kind = cur_kind;

        case (r_phase)
            PH_OPCODE: begin
                n_fin    = |(i_byte & FIN_MASK);
                n_opcode = 4'(i_byte & OPCODE_MASK);
                n_phase  = PH_LEN;
            end
            PH_LEN: begin
                if (len7 < LEN_EXT16) begin
                    hdr_len = {9'd0, len7};
                    n_len   = hdr_len;
                    n_seen  = 16'd0;
                    if (hdr_len == 16'd0) begin
                        n_phase       = PH_OPCODE;
                        emit          = 1'b1;
                        res.frame_end = 1'b1;
                    end else begin
                        n_phase = PH_PAYLOAD;
                    end
                end else if (len7 == LEN_EXT16) begin
                    n_len   = 16'd0;
                    n_phase = PH_LEN_HI;
                end else begin
                    // 64-bit length: report and stop
                    n_phase        = PH_HALT;
                    emit           = 1'b1;
                    res.frame_kind = KIND_LENERR;
                    res.frame_end  = 1'b1;
                end
            end
            PH_LEN_HI: begin
                n_len   = {i_byte, 8'h00};
                n_phase = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                hdr_len = r_len | {8'h00, i_byte};
                n_len   = hdr_len;
                n_seen  = 16'd0;
                if (hdr_len == 16'd0) begin
                    n_phase       = PH_OPCODE;
                    emit          = 1'b1;
                    res.frame_end = 1'b1;
                end else begin
                    n_phase = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                n_seen = seen_inc;
                if (fwd && (cur_kind == KIND_BINARY)) begin
                    n_audio = r_audio + 32'd1;
                end
                res.has_byte     = fwd;
                res.payload_byte = fwd ? i_byte : 8'h00;
                res.truncated    = over;
                if (last) begin
                    n_phase       = PH_OPCODE;
                    emit          = 1'b1;
                    res.frame_end = 1'b1;
                end else begin
                    emit = fwd;
                end
            end
            PH_HALT: begin
                // ignore everything until reset
            end
            default: begin
                n_phase = PH_OPCODE;
            end
        endcase

        // Fields common to every result
        res.raw_opcode        = n_opcode;
        res.fin_flag          = n_fin;
        res.audio_byte_total  = n_audio;
        res.reconnect_request = (res.frame_end && (res.frame_kind == KIND_CLOSE)) ||
                                (res.frame_kind == KIND_LENERR);
        res.pong_request      = res.frame_end && (res.frame_kind == KIND_PING);
    end

    assign o_res_valid = i_accept && emit;
    assign o_res       = res;

    // Parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_OPCODE;
            r_opcode <= 4'd0;
            r_fin    <= 1'b0;
            r_len    <= 16'd0;
            r_seen   <= 16'd0;
            r_audio  <= 32'd0;
        end else if (i_accept) begin
            r_phase  <= n_phase;
            r_opcode <= n_opcode;
            r_fin    <= n_fin;
            r_len    <= n_len;
            r_seen   <= n_seen;
            r_audio  <= n_audio;
        end
    end

endmodule

### hdl/wsfd_outbuf.sv
// Result register with one skid entry; keeps the input side moving under output stall.
// Depends on wsfd_pkg.
module wsfd_outbuf import wsfd_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_res_valid,
    input  t_result i_res,
    output logic    o_full,
    output logic    o_valid,
    input  logic    i_stall,
    output t_result o_res
);

    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out;
    t_result r_skid;
    logic    take;

    assign take    = r_out_valid && !i_stall;
    assign o_valid = r_out_valid;
    assign o_res   = r_out;
    assign o_full  = r_skid_valid;

    // Control: skid drains first; new results never arrive while skid is full
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (take || !r_out_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end
        end else if (i_res_valid) begin
            if (r_out_valid && !take) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end else if (take) begin
            r_out_valid <= 1'b0;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (take || !r_out_valid) begin
                r_out <= r_skid;
            end
        end else if (i_res_valid) begin
            if (r_out_valid && !take) begin
                r_skid <= i_res;
            end else begin
                r_out <= i_res;
            end
        end
    end

endmodule

### hdl/websocket_frame_deframer_top.sv
// WebSocket frame deframer, top level. Depends on wsfd_pkg, wsfd_parser, wsfd_outbuf.
// Each result is registered in wsfd_outbuf, in the output register or the skid entry.
// Throughput: one byte per cycle while o_stall is low; the parser state updates once per accepted byte.
// Input stall rises only when the skid entry holds a result behind a stalled output.
// Reset (synchronous, active low) returns the parser to the opcode byte, clears
// counters and buffers, and sets payload_cap to 16384.
`include "websocket_frame_deframer_top_defines.svh"

module websocket_frame_deframer_top import wsfd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // byte input
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_stream_byte,
    // configuration write
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_payload_cap,
    // result output
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_frame_kind,
    output logic [3:0]  o_raw_opcode,
    output logic [7:0]  o_payload_byte,
    output logic        o_has_byte,
    output logic        o_frame_end,
    output logic        o_fin_flag,
    output logic        o_truncated,
    output logic        o_reconnect_request,
    output logic        o_pong_request,
    output logic [31:0] o_audio_byte_total
);

    logic [15:0] r_payload_cap;
    logic        accept;
    logic        buf_full;
    logic        res_valid;
    t_result     res;
    t_result     out_res;

    // Configuration register
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_payload_cap <= CAP_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_payload_cap <= i_cfg_payload_cap;
        end
    end

    // Input transfer
    assign o_stall = buf_full;
    assign accept  = i_valid && !buf_full;

    wsfd_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_byte      (i_stream_byte),
        .i_cap       (r_payload_cap),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    wsfd_outbuf u_outbuf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (res_valid),
        .i_res       (res),
        .o_full      (buf_full),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_res       (out_res)
    );

    // Result fields
    assign o_frame_kind        = out_res.frame_kind;
    assign o_raw_opcode        = out_res.raw_opcode;
    assign o_payload_byte      = out_res.payload_byte;
    assign o_has_byte          = out_res.has_byte;
    assign o_frame_end         = out_res.frame_end;
    assign o_fin_flag          = out_res.fin_flag;
    assign o_truncated         = out_res.truncated;
    assign o_reconnect_request = out_res.reconnect_request;
    assign o_pong_request      = out_res.pong_request;
    assign o_audio_byte_total  = out_res.audio_byte_total;

    // Checks
    `WSFD_ASSERT_IMPL(a_skid_behind_out, i_clk, i_rst_n, buf_full, o_valid)
    `WSFD_ASSERT_IMPL(a_reconnect_ends, i_clk, i_rst_n, o_valid && o_reconnect_request, o_frame_end)
    `WSFD_ASSERT_IMPL(a_trunc_data_only, i_clk, i_rst_n, o_valid && o_truncated, (o_frame_kind == KIND_TEXT) || (o_frame_kind == KIND_BINARY))
    `WSFD_ASSERT_NEXT(a_stall_no_accept, i_clk, i_rst_n, buf_full && i_stall, buf_full)

endmodule
